>>> rtl/lcs_pkg.sv
package lcs_pkg;

  // Event codes carried in the action field
  typedef enum logic [2:0] {
    ACT_TICK          = 3'd0,
    ACT_INIT          = 3'd1,
    ACT_CONNECT       = 3'd2,
    ACT_CONNECT_SAVED = 3'd3,
    ACT_FORGET        = 3'd4,
    ACT_DISCONNECT    = 3'd5,
    ACT_START_SCAN    = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_SCANNING   = 3'd1,
    ST_CONNECTING = 3'd2,
    ST_CONNECTED  = 3'd3,
    ST_FAILED     = 3'd4,
    ST_RETRY      = 3'd5
  } conn_state_t;

  typedef enum logic [1:0] {
    FAIL_NONE    = 2'd0,
    FAIL_NO_AP   = 2'd1,
    FAIL_AUTH    = 2'd2,
    FAIL_TIMEOUT = 2'd3
  } fail_t;

  typedef enum logic [2:0] {
    NOTE_NONE      = 3'd0,
    NOTE_CONNECTED = 3'd1,
    NOTE_NO_AP     = 3'd2,
    NOTE_AUTH      = 3'd3,
    NOTE_TIMEOUT   = 3'd4,
    NOTE_LOST      = 3'd5
  } notice_t;

  typedef enum logic [1:0] {
    LINK_OTHER     = 2'd0,
    LINK_CONNECTED = 2'd1,
    LINK_NO_AP     = 2'd2,
    LINK_FAILED    = 2'd3
  } link_t;

  typedef enum logic [1:0] {
    CFG_AUTO_CONNECT    = 2'd0,
    CFG_CONNECT_TIMEOUT = 2'd1,
    CFG_RETRY_INTERVAL  = 2'd2,
    CFG_FAIL_HOLD       = 2'd3
  } cfg_index_t;

  localparam int TimeW  = 32;
  localparam int LimitW = 20;
  localparam int CfgIdxW = 2;

  localparam logic [LimitW-1:0] DEF_CONN_LIMIT_MS = 20'd15000;
  localparam logic [LimitW-1:0] DEF_RETRY_WAIT_MS = 20'd15000;
  localparam logic [LimitW-1:0] DEF_FAIL_HOLD_MS  = 20'd3000;

  typedef struct packed {
    logic              auto_connect;
    logic [LimitW-1:0] conn_limit_ms;
    logic [LimitW-1:0] retry_wait_ms;
    logic [LimitW-1:0] fail_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [TimeW-1:0] now_ms;
    logic [1:0]       link_status;
    logic             scan_running;
    logic             ssid_present;
  } event_t;

  typedef struct packed {
    logic [2:0] conn_state;
    logic [1:0] fail_reason;
    logic [2:0] notice;
    logic       begin_connect;
    logic       drop_link;
    logic       begin_scan;
    logic       collect_scan;
    logic       trigger_sync;
    logic       clear_info;
    logic       creds_present;
  } result_t;

endpackage

>>> rtl/lcs_if.sv
interface lcs_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] now_ms;
  logic [1:0]  link_status;
  logic        scan_running;
  logic        ssid_present;

  modport source (output valid, action, now_ms, link_status, scan_running, ssid_present,
                  input ready);
  modport sink (input valid, action, now_ms, link_status, scan_running, ssid_present,
                output ready);
endinterface

interface lcs_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] conn_state;
  logic [1:0] fail_reason;
  logic [2:0] notice;
  logic       begin_connect;
  logic       drop_link;
  logic       begin_scan;
  logic       collect_scan;
  logic       trigger_sync;
  logic       clear_info;
  logic       creds_present;

  modport source (output valid, conn_state, fail_reason, notice, begin_connect, drop_link,
                  begin_scan, collect_scan, trigger_sync, clear_info, creds_present,
                  input ready);
  modport sink (input valid, conn_state, fail_reason, notice, begin_connect, drop_link,
                begin_scan, collect_scan, trigger_sync, clear_info, creds_present,
                output ready);
endinterface

>>> rtl/link_connection_supervisor_top.sv
// Radio link connection supervisor. Each input beat is one event: a poll tick
// (link status, scan-running flag, ssid flag, millisecond timestamp) or a
// command (init, connect, connect saved, forget, disconnect, start scan).
// Every event yields exactly one result beat with the connection state, the
// failure reason, the saved-credentials flag, a notice code and one-shot
// request flags. Rate: one event per clock sustained while the result sink
// stays ready. An accepted event passes through the input register, then the
// state update and result register. The state registers advance in the same
// cycle the result register loads, so consecutive events see each other's
// effect. Timeouts use wrapping 32-bit elapsed time (now_ms minus state entry
// time) and fire only when strictly greater than the programmed limit. Write
// the configuration registers only while no event is in flight.
module link_connection_supervisor_top
  import lcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [LimitW-1:0]  cfg_data,
  lcs_event_if.sink          evt,
  lcs_result_if.source       res
);

  cfg_t    cfg;
  event_t  s1_evt;
  logic    s1_valid;
  logic    out_valid;
  result_t out_res;
  result_t core_res;
  logic    advance;

  // Stage 1 moves into the result register when that register is empty
  // or is being drained this cycle.
  assign advance   = s1_valid && (!out_valid || res.ready);
  assign evt.ready = !s1_valid || advance;

  lcs_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  lcs_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .ev   (s1_evt),
    .cfg  (cfg),
    .res  (core_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s1_evt.action       <= evt.action;
      s1_evt.now_ms       <= evt.now_ms;
      s1_evt.link_status  <= evt.link_status;
      s1_evt.scan_running <= evt.scan_running;
      s1_evt.ssid_present <= evt.ssid_present;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign res.valid         = out_valid;
  assign res.conn_state    = out_res.conn_state;
  assign res.fail_reason   = out_res.fail_reason;
  assign res.notice        = out_res.notice;
  assign res.begin_connect = out_res.begin_connect;
  assign res.drop_link     = out_res.drop_link;
  assign res.begin_scan    = out_res.begin_scan;
  assign res.collect_scan  = out_res.collect_scan;
  assign res.trigger_sync  = out_res.trigger_sync;
  assign res.clear_info    = out_res.clear_info;
  assign res.creds_present = out_res.creds_present;

`ifndef SYNTHESIS
  // A full pipe facing a stalled sink must not take another beat
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !res.ready) |-> !evt.ready)
    else $error("input accepted while pipe is full");

  a_scan_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.begin_scan) |-> (out_res.conn_state == ST_SCANNING))
    else $error("begin_scan without scanning state");

  a_connect_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.begin_connect) |-> (out_res.conn_state == ST_CONNECTING))
    else $error("begin_connect without connecting state");

  a_sync_notice: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.trigger_sync) |->
      (out_res.conn_state == ST_CONNECTED && out_res.notice == NOTE_CONNECTED))
    else $error("trigger_sync without connected notice");
`endif

endmodule

>>> rtl/lcs_cfg.sv
module lcs_cfg
  import lcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [CfgIdxW-1:0] index,
  input  logic [LimitW-1:0]  data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_connect  <= 1'b1;
      cfg.conn_limit_ms <= DEF_CONN_LIMIT_MS;
      cfg.retry_wait_ms <= DEF_RETRY_WAIT_MS;
      cfg.fail_hold_ms  <= DEF_FAIL_HOLD_MS;
    end else if (we) begin
      case (cfg_index_t'(index))
        CFG_AUTO_CONNECT:    cfg.auto_connect  <= data[0];
        CFG_CONNECT_TIMEOUT: cfg.conn_limit_ms <= data;
        CFG_RETRY_INTERVAL:  cfg.retry_wait_ms <= data;
        CFG_FAIL_HOLD:       cfg.fail_hold_ms  <= data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/lcs_core.sv
module lcs_core
  import lcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  event_t  ev,
  input  cfg_t    cfg,
  output result_t res
);

  conn_state_t      state, state_next;
  logic [TimeW-1:0] entry_time, entry_time_next;
  fail_t            fail_code, fail_code_next;
  logic             creds_saved, creds_saved_next;
  logic             scan_queued, scan_queued_next;

  logic [TimeW-1:0]  elapsed;
  logic [LimitW-1:0] limit;
  logic              timed_out;
  logic              retry_armed;
  logic              is_link_up;

  assign retry_armed = cfg.auto_connect && creds_saved;
  assign is_link_up  = (link_t'(ev.link_status) == LINK_CONNECTED);

  // One shared elapsed-time compare; the limit depends on the current state
  always_comb begin
    case (state)
      ST_CONNECTING: limit = cfg.conn_limit_ms;
      ST_RETRY:      limit = retry_armed ? cfg.retry_wait_ms : cfg.fail_hold_ms;
      default:       limit = cfg.fail_hold_ms;
    endcase
  end

  assign elapsed   = ev.now_ms - entry_time;
  assign timed_out = elapsed > {{(TimeW-LimitW){1'b0}}, limit};

  always_comb begin
    state_next       = state;
    entry_time_next  = entry_time;
    fail_code_next   = fail_code;
    creds_saved_next = creds_saved;
    scan_queued_next = scan_queued;
    res              = '0;

    case (action_t'(ev.action))
      ACT_TICK: begin
        case (state)
          ST_IDLE: begin
            if (is_link_up) begin
              state_next      = ST_CONNECTED;
              entry_time_next = ev.now_ms;
              res.trigger_sync = 1'b1;
              res.notice       = NOTE_CONNECTED;
            end
          end
          ST_SCANNING: begin
            if (!ev.scan_running) begin
              res.collect_scan = 1'b1;
              entry_time_next  = ev.now_ms;
              state_next       = is_link_up ? ST_CONNECTED : ST_IDLE;
              if (scan_queued) begin
                scan_queued_next = 1'b0;
                if (creds_saved) begin
                  res.begin_connect = 1'b1;
                  state_next        = ST_CONNECTING;
                end
              end
            end
          end
          ST_CONNECTING: begin
            case (link_t'(ev.link_status))
              LINK_CONNECTED: begin
                if (ev.ssid_present) creds_saved_next = 1'b1;
                state_next       = ST_CONNECTED;
                entry_time_next  = ev.now_ms;
                res.trigger_sync = 1'b1;
                res.notice       = NOTE_CONNECTED;
              end
              LINK_NO_AP: begin
                fail_code_next  = FAIL_NO_AP;
                state_next      = ST_FAILED;
                entry_time_next = ev.now_ms;
                res.notice      = NOTE_NO_AP;
              end
              LINK_FAILED: begin
                fail_code_next  = FAIL_AUTH;
                state_next      = ST_FAILED;
                entry_time_next = ev.now_ms;
                res.notice      = NOTE_AUTH;
              end
              default: begin
                if (timed_out) begin
                  fail_code_next  = FAIL_TIMEOUT;
                  res.drop_link   = 1'b1;
                  state_next      = ST_FAILED;
                  entry_time_next = ev.now_ms;
                  res.notice      = NOTE_TIMEOUT;
                end
              end
            endcase
          end
          ST_CONNECTED: begin
            if (!is_link_up) begin
              state_next      = ST_RETRY;
              entry_time_next = ev.now_ms;
              res.notice      = NOTE_LOST;
              res.clear_info  = 1'b1;
            end
          end
          ST_FAILED: begin
            if (timed_out) begin
              state_next      = ST_IDLE;
              entry_time_next = ev.now_ms;
            end
          end
          ST_RETRY: begin
            if (timed_out) begin
              entry_time_next = ev.now_ms;
              if (retry_armed) begin
                res.begin_connect = 1'b1;
                state_next        = ST_CONNECTING;
              end else begin
                state_next = ST_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      ACT_INIT: begin
        creds_saved_next = creds_saved | ev.ssid_present;
        entry_time_next  = ev.now_ms;
        if (cfg.auto_connect && creds_saved_next) begin
          res.begin_connect = 1'b1;
          state_next        = ST_CONNECTING;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ACT_CONNECT: begin
        fail_code_next    = FAIL_NONE;
        res.drop_link     = 1'b1;
        creds_saved_next  = ev.ssid_present;
        res.begin_connect = 1'b1;
        state_next        = ST_CONNECTING;
        entry_time_next   = ev.now_ms;
      end
      ACT_CONNECT_SAVED: begin
        if (creds_saved) begin
          if (state == ST_SCANNING) begin
            scan_queued_next = 1'b1;
          end else begin
            res.begin_connect = 1'b1;
            state_next        = ST_CONNECTING;
            entry_time_next   = ev.now_ms;
          end
        end
      end
      ACT_FORGET: begin
        res.drop_link    = 1'b1;
        creds_saved_next = 1'b0;
        state_next       = ST_IDLE;
        entry_time_next  = ev.now_ms;
      end
      ACT_DISCONNECT: begin
        res.drop_link   = 1'b1;
        state_next      = ST_IDLE;
        entry_time_next = ev.now_ms;
      end
      ACT_START_SCAN: begin
        if (state == ST_CONNECTING) begin
          scan_queued_next = 1'b1;
        end else begin
          res.begin_scan  = 1'b1;
          state_next      = ST_SCANNING;
          entry_time_next = ev.now_ms;
        end
      end
      default: ;
    endcase

    res.conn_state    = state_next;
    res.fail_reason   = fail_code_next;
    res.creds_present = creds_saved_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_time  <= '0;
      fail_code   <= FAIL_NONE;
      creds_saved <= 1'b0;
      scan_queued <= 1'b0;
    end else if (step) begin
      state       <= state_next;
      entry_time  <= entry_time_next;
      fail_code   <= fail_code_next;
      creds_saved <= creds_saved_next;
      scan_queued <= scan_queued_next;
    end
  end

endmodule

>>> tb/sv/link_connection_supervisor_top_test.sv
`timescale 1ns / 1ps

module link_connection_supervisor_top_test;
  import lcs_pkg::*;

  // Action code 7 has no meaning; the block must leave its state alone.
  localparam logic [2:0] ACT_UNDEFINED = 3'd7;
  localparam int PHASES = 6;
  localparam int BEATS_PER_PHASE = 100;
  localparam int IDLE_PCT = 17;
  localparam int MAX_PRINTS = 40;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [LimitW-1:0] cfg_data;

  lcs_event_if  evt_if ();
  lcs_result_if res_if ();

  link_connection_supervisor_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_if),
    .res       (res_if)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the supervisor registers and settings.
  // ---------------------------------------------------------------------------
  conn_state_t       sup_state  = ST_IDLE;
  logic [TimeW-1:0]  sup_entry  = '0;
  logic [1:0]        sup_fail   = FAIL_NONE;
  logic              sup_creds  = 1'b0;
  logic              sup_queued = 1'b0;

  logic              cfg_auto    = 1'b1;
  logic [LimitW-1:0] cfg_conn_to = DEF_CONN_LIMIT_MS;
  logic [LimitW-1:0] cfg_retry   = DEF_RETRY_WAIT_MS;
  logic [LimitW-1:0] cfg_hold    = DEF_FAIL_HOLD_MS;

  result_t pending_results[$];

  // Directed rows; want is only used when typed is set.
  typedef struct {
    event_t  ev;
    bit      typed;
    result_t want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  // Side channel from the driver to the acceptance monitor.
  bit      row_typed;
  result_t row_want;

  bit          calm = 1'b0;         // no idling on either side while set
  logic [31:0] clock_ms = '0;       // running timestamp for random events
  int          failures = 0;
  int          prints = 0;
  int          events_sent = 0;
  int          results_seen = 0;
  int          settings_used = 1;   // reset values count as the first
  int          n_conn = 0, n_lost = 0, n_tmo = 0, n_noap = 0, n_auth = 0, n_scan = 0;

  function automatic void enter_state(input conn_state_t s, input logic [TimeW-1:0] t);
    sup_state = s;
    sup_entry = t;
  endfunction

  // One event in, one result out; updates the predictor state.
  function automatic result_t supervise_event(input event_t ev);
    result_t r;
    logic [TimeW-1:0] elapsed;
    r = '0;
    elapsed = ev.now_ms - sup_entry;  // wraps mod 2^32
    case (ev.action)
      ACT_TICK: begin
        case (sup_state)
          ST_IDLE: begin
            if (ev.link_status == LINK_CONNECTED) begin
              enter_state(ST_CONNECTED, ev.now_ms);
              r.trigger_sync = 1'b1;
              r.notice = NOTE_CONNECTED;
            end
          end
          ST_SCANNING: begin
            if (!ev.scan_running) begin
              r.collect_scan = 1'b1;
              // landing in connected from a scan raises no sync and no notice
              if (ev.link_status == LINK_CONNECTED) enter_state(ST_CONNECTED, ev.now_ms);
              else enter_state(ST_IDLE, ev.now_ms);
              if (sup_queued) begin
                sup_queued = 1'b0;
                if (sup_creds) begin
                  r.begin_connect = 1'b1;
                  enter_state(ST_CONNECTING, ev.now_ms);
                end
              end
            end
          end
          ST_CONNECTING: begin
            if (ev.link_status == LINK_CONNECTED) begin
              if (ev.ssid_present) sup_creds = 1'b1;
              enter_state(ST_CONNECTED, ev.now_ms);
              r.trigger_sync = 1'b1;
              r.notice = NOTE_CONNECTED;
            end else if (ev.link_status == LINK_NO_AP) begin
              sup_fail = FAIL_NO_AP;
              enter_state(ST_FAILED, ev.now_ms);
              r.notice = NOTE_NO_AP;
            end else if (ev.link_status == LINK_FAILED) begin
              sup_fail = FAIL_AUTH;
              enter_state(ST_FAILED, ev.now_ms);
              r.notice = NOTE_AUTH;
            end else if (elapsed > TimeW'(cfg_conn_to)) begin
              sup_fail = FAIL_TIMEOUT;
              r.drop_link = 1'b1;
              enter_state(ST_FAILED, ev.now_ms);
              r.notice = NOTE_TIMEOUT;
            end
          end
          ST_CONNECTED: begin
            if (ev.link_status != LINK_CONNECTED) begin
              enter_state(ST_RETRY, ev.now_ms);
              r.notice = NOTE_LOST;
              r.clear_info = 1'b1;
            end
          end
          ST_FAILED: begin
            if (elapsed > TimeW'(cfg_hold)) enter_state(ST_IDLE, ev.now_ms);
          end
          ST_RETRY: begin
            if (cfg_auto && sup_creds) begin
              if (elapsed > TimeW'(cfg_retry)) begin
                r.begin_connect = 1'b1;
                enter_state(ST_CONNECTING, ev.now_ms);
              end
            end else if (elapsed > TimeW'(cfg_hold)) begin
              enter_state(ST_IDLE, ev.now_ms);
            end
          end
          default: ;
        endcase
      end
      ACT_INIT: begin
        if (ev.ssid_present) sup_creds = 1'b1;
        if (cfg_auto && sup_creds) begin
          r.begin_connect = 1'b1;
          enter_state(ST_CONNECTING, ev.now_ms);
        end else begin
          enter_state(ST_IDLE, ev.now_ms);
        end
      end
      ACT_CONNECT: begin
        sup_fail = FAIL_NONE;
        r.drop_link = 1'b1;
        sup_creds = ev.ssid_present;
        r.begin_connect = 1'b1;
        enter_state(ST_CONNECTING, ev.now_ms);
      end
      ACT_CONNECT_SAVED: begin
        if (sup_creds) begin
          if (sup_state == ST_SCANNING) begin
            sup_queued = 1'b1;
          end else begin
            r.begin_connect = 1'b1;
            enter_state(ST_CONNECTING, ev.now_ms);
          end
        end
      end
      ACT_FORGET: begin
        r.drop_link = 1'b1;
        sup_creds = 1'b0;
        enter_state(ST_IDLE, ev.now_ms);
      end
      ACT_DISCONNECT: begin
        r.drop_link = 1'b1;
        enter_state(ST_IDLE, ev.now_ms);
      end
      ACT_START_SCAN: begin
        if (sup_state == ST_CONNECTING) begin
          sup_queued = 1'b1;
        end else begin
          r.begin_scan = 1'b1;
          enter_state(ST_SCANNING, ev.now_ms);
        end
      end
      default: ;
    endcase
    r.conn_state    = sup_state;
    r.fail_reason   = sup_fail;
    r.creds_present = sup_creds;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] a, input logic [31:0] t, input link_t l,
                                  input bit s, input bit id);
    stim_row_t row;
    row.ev = '{action: a, now_ms: t, link_status: l, scan_running: s, ssid_present: id};
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  // Same, with the result spelled out by hand.
  function automatic void add_typed(input logic [2:0] a, input logic [31:0] t, input link_t l,
                                    input bit s, input bit id, input result_t w);
    stim_row_t row;
    row.ev = '{action: a, now_ms: t, link_status: l, scan_running: s, ssid_present: id};
    row.typed = 1'b1;
    row.want = w;
    directed_rows.push_back(row);
  endfunction

  // Directed sequence, run with the reset settings (auto on, 15000/15000/3000).
  function automatic void build_directed();
    // fresh out of reset: idle tick, then an undefined code with every field at max
    add_typed(ACT_TICK, 32'd0, LINK_OTHER, 1'b0, 1'b0, '0);
    add_typed(ACT_UNDEFINED, 32'hFFFF_FFFF, LINK_FAILED, 1'b1, 1'b1, '0);
    // init with no stored name and connect-saved without creds both stay idle
    add_typed(ACT_INIT, 32'd1, LINK_OTHER, 1'b0, 1'b0, '0);
    add_typed(ACT_CONNECT_SAVED, 32'd2, LINK_OTHER, 1'b0, 1'b1, '0);
    add_typed(ACT_TICK, 32'd5, LINK_CONNECTED, 1'b0, 1'b0,
              '{ST_CONNECTED, FAIL_NONE, NOTE_CONNECTED, 1'b0, 1'b0, 1'b0, 1'b0,
                1'b1, 1'b0, 1'b0});
    add_typed(ACT_TICK, 32'd10, LINK_OTHER, 1'b0, 1'b0,
              '{ST_RETRY, FAIL_NONE, NOTE_LOST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0});
    // retry without creds falls back to idle one ms past the hold
    add_row(ACT_TICK, 32'd3011, LINK_OTHER, 1'b0, 1'b0);
    add_row(ACT_CONNECT, 32'd100000, LINK_OTHER, 1'b0, 1'b1);
    // timeout boundary: equal is not past, one more is
    add_row(ACT_TICK, 32'd115000, LINK_OTHER, 1'b0, 1'b0);
    add_typed(ACT_TICK, 32'd115001, LINK_OTHER, 1'b0, 1'b0,
              '{ST_FAILED, FAIL_TIMEOUT, NOTE_TIMEOUT, 1'b0, 1'b1, 1'b0, 1'b0,
                1'b0, 1'b0, 1'b1});
    add_row(ACT_START_SCAN, 32'd120000, LINK_OTHER, 1'b0, 1'b0);
    add_row(ACT_START_SCAN, 32'd120010, LINK_OTHER, 1'b1, 1'b0);   // restart
    add_row(ACT_CONNECT_SAVED, 32'd120020, LINK_OTHER, 1'b1, 1'b0); // queued
    add_row(ACT_TICK, 32'd120040, LINK_OTHER, 1'b0, 1'b0);          // queued connect fires
    add_row(ACT_START_SCAN, 32'd120050, LINK_OTHER, 1'b0, 1'b0);    // queued again
    add_typed(ACT_TICK, 32'd120060, LINK_NO_AP, 1'b0, 1'b0,
              '{ST_FAILED, FAIL_NO_AP, NOTE_NO_AP, 1'b0, 1'b0, 1'b0, 1'b0,
                1'b0, 1'b0, 1'b1});
    add_row(ACT_CONNECT_SAVED, 32'd120070, LINK_OTHER, 1'b0, 1'b0);
    add_typed(ACT_TICK, 32'd120080, LINK_FAILED, 1'b0, 1'b0,
              '{ST_FAILED, FAIL_AUTH, NOTE_AUTH, 1'b0, 1'b0, 1'b0, 1'b0,
                1'b0, 1'b0, 1'b1});
    add_row(ACT_START_SCAN, 32'd120090, LINK_OTHER, 1'b0, 1'b0);
    add_row(ACT_TICK, 32'd120100, LINK_CONNECTED, 1'b0, 1'b0);
    add_row(ACT_TICK, 32'd120110, LINK_CONNECTED, 1'b0, 1'b1);
    add_row(ACT_START_SCAN, 32'd120120, LINK_CONNECTED, 1'b0, 1'b0);
    add_row(ACT_TICK, 32'd120130, LINK_CONNECTED, 1'b0, 1'b0);      // scan -> connected
    // link lost just before the timestamp wraps; retry fires across the wrap
    add_row(ACT_TICK, 32'hFFFF_F000, LINK_NO_AP, 1'b0, 1'b0);
    add_row(ACT_TICK, 32'h0000_2A99, LINK_OTHER, 1'b0, 1'b0);
    add_row(ACT_INIT, 32'h0000_3000, LINK_OTHER, 1'b0, 1'b1);
    add_row(ACT_FORGET, 32'h0000_3001, LINK_CONNECTED, 1'b1, 1'b1);
    add_row(ACT_DISCONNECT, 32'h8000_0000, LINK_OTHER, 1'b0, 1'b0);
  endfunction

  // Random event; timestamps step forward, now and then jump anywhere or
  // land on a limit boundary, or one past it, relative to the current entry time.
  function automatic event_t make_event();
    event_t ev;
    int unsigned k;
    logic [LimitW-1:0] lim;
    k = $urandom_range(0, 99);
    if (k < 4) begin
      clock_ms = $urandom();
    end else if (k < 22) begin
      case ($urandom_range(0, 2))
        0:       lim = cfg_conn_to;
        1:       lim = cfg_retry;
        default: lim = cfg_hold;
      endcase
      clock_ms = sup_entry + 32'(lim) + $urandom_range(0, 1);
    end else begin
      clock_ms = clock_ms + $urandom_range(0, cfg_hold / 4 + 2);
    end
    ev.now_ms = clock_ms;

    k = $urandom_range(0, 99);
    if (k < 55)      ev.action = ACT_TICK;
    else if (k < 62) ev.action = ACT_INIT;
    else if (k < 70) ev.action = ACT_CONNECT;
    else if (k < 80) ev.action = ACT_CONNECT_SAVED;
    else if (k < 84) ev.action = ACT_FORGET;
    else if (k < 88) ev.action = ACT_DISCONNECT;
    else if (k < 97) ev.action = ACT_START_SCAN;
    else             ev.action = ACT_UNDEFINED;

    k = $urandom_range(0, 99);
    if (k < 50)      ev.link_status = LINK_OTHER;
    else if (k < 75) ev.link_status = LINK_CONNECTED;
    else if (k < 88) ev.link_status = LINK_NO_AP;
    else             ev.link_status = LINK_FAILED;

    ev.scan_running = 1'($urandom_range(0, 1));
    ev.ssid_present = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // Drive one event beat; returns at the falling edge after acceptance.
  task automatic push_event(input event_t ev, input bit typed, input result_t want);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      evt_if.valid <= 1'b0;
      @(negedge clk);
    end
    evt_if.valid        <= 1'b1;
    evt_if.action       <= ev.action;
    evt_if.now_ms       <= ev.now_ms;
    evt_if.link_status  <= ev.link_status;
    evt_if.scan_running <= ev.scan_running;
    evt_if.ssid_present <= ev.ssid_present;
    row_typed           <= typed;
    row_want            <= want;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait until every predicted result is back, then let the pipe settle.
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all four registers back to back; block must be idle.
  task automatic apply_settings(input logic a, input logic [LimitW-1:0] t,
                                input logic [LimitW-1:0] r, input logic [LimitW-1:0] h);
    cfg_index_t idx [4];
    logic [LimitW-1:0] vals [4];
    idx  = '{CFG_AUTO_CONNECT, CFG_CONNECT_TIMEOUT, CFG_RETRY_INTERVAL, CFG_FAIL_HOLD};
    vals = '{LimitW'(a), t, r, h};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cfg_auto    = a;
    cfg_conn_to = t;
    cfg_retry   = r;
    cfg_hold    = h;
    settings_used++;
  endtask

  function automatic void check_field(input string name, input logic [2:0] want,
                                      input logic [2:0] got);
    if (want !== got) begin
      failures++;
      if (prints < MAX_PRINTS) begin
        prints++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endfunction

  // Sink side stalls at random, except during the calm phase.
  always @(negedge clk) begin
    if (!rst) res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Predict on every accepted event beat.
  always @(posedge clk) begin : watch_events
    result_t p;
    if (!rst && evt_if.valid && evt_if.ready) begin
      p = supervise_event('{action: evt_if.action, now_ms: evt_if.now_ms,
                            link_status: evt_if.link_status,
                            scan_running: evt_if.scan_running,
                            ssid_present: evt_if.ssid_present});
      if (row_typed) pending_results.push_back(row_want);
      else pending_results.push_back(p);
      events_sent++;
    end
  end

  // Compare every accepted result beat against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        failures++;
        if (prints < MAX_PRINTS) begin
          prints++;
          $display("%0t: result beat with nothing expected: expected none, actual state %0d",
                   $time, res_if.conn_state);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("conn_state", want.conn_state, res_if.conn_state);
        check_field("fail_reason", 3'(want.fail_reason), 3'(res_if.fail_reason));
        check_field("notice", want.notice, res_if.notice);
        check_field("begin_connect", 3'(want.begin_connect), 3'(res_if.begin_connect));
        check_field("drop_link", 3'(want.drop_link), 3'(res_if.drop_link));
        check_field("begin_scan", 3'(want.begin_scan), 3'(res_if.begin_scan));
        check_field("collect_scan", 3'(want.collect_scan), 3'(res_if.collect_scan));
        check_field("trigger_sync", 3'(want.trigger_sync), 3'(res_if.trigger_sync));
        check_field("clear_info", 3'(want.clear_info), 3'(res_if.clear_info));
        check_field("creds_present", 3'(want.creds_present), 3'(res_if.creds_present));
        case (want.notice)
          NOTE_CONNECTED: n_conn++;
          NOTE_LOST:      n_lost++;
          NOTE_TIMEOUT:   n_tmo++;
          NOTE_NO_AP:     n_noap++;
          NOTE_AUTH:      n_auth++;
          default: ;
        endcase
        if (want.collect_scan) n_scan++;
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases over several settings.
  initial begin : stimulus
    logic              a;
    logic [LimitW-1:0] t, r, h;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_AUTO_CONNECT;
    cfg_data            = '0;
    evt_if.valid        = 1'b0;
    evt_if.action       = ACT_TICK;
    evt_if.now_ms       = '0;
    evt_if.link_status  = LINK_OTHER;
    evt_if.scan_running = 1'b0;
    evt_if.ssid_present = 1'b0;
    res_if.ready        = 1'b0;
    row_typed           = 1'b0;
    row_want            = '0;
    build_directed();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      push_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
    evt_if.valid <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin  // reset values, written explicitly
          a = 1'b1; t = DEF_CONN_LIMIT_MS; r = DEF_RETRY_WAIT_MS;
          h = DEF_FAIL_HOLD_MS;
        end
        1: begin  // smallest limits, auto connect off
          a = 1'b0; t = 20'd1; r = 20'd1; h = 20'd1;
        end
        2: begin  // largest limits
          a = 1'b1; t = 20'hFFFFF; r = 20'hFFFFF; h = 20'hFFFFF;
        end
        5: begin  // anywhere in range
          a = 1'($urandom_range(0, 1));
          t = LimitW'($urandom_range(1, 20'hFFFFF));
          r = LimitW'($urandom_range(1, 20'hFFFFF));
          h = LimitW'($urandom_range(1, 20'hFFFFF));
        end
        default: begin  // short limits so timeouts show up often
          a = 1'($urandom_range(0, 1));
          t = LimitW'($urandom_range(1, 4000));
          r = LimitW'($urandom_range(1, 4000));
          h = LimitW'($urandom_range(1, 4000));
        end
      endcase
      apply_settings(a, t, r, h);
      calm = (p == 2);  // one long stretch with no idling at all
      repeat (BEATS_PER_PHASE) push_event(make_event(), 1'b0, '0);
      evt_if.valid <= 1'b0;
      drain();
      calm = 1'b0;
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d results from %0d events (%0d directed) over %0d register settings.",
             results_seen, events_sent, directed_rows.size(), settings_used);
    $display("Notices: connected %0d, lost %0d, timeout %0d, no AP %0d, auth %0d; scans %0d.",
             n_conn, n_lost, n_tmo, n_noap, n_auth, n_scan);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/lcs_pkg.sv
rtl/lcs_if.sv
rtl/lcs_cfg.sv
rtl/lcs_core.sv
rtl/link_connection_supervisor_top.sv
tb/sv/link_connection_supervisor_top_test.sv
